/* hdl/ostb_pkg.sv */
// ----------------------------------------------------------------------------
// ostb_pkg: shared types and constants for the one-shot timer bank
// Command and status codes, field widths and the stopped time value.
// ----------------------------------------------------------------------------
package ostb_pkg;

	// Field widths of the command and result beats
	localparam int unsigned CMD_W     = 3;
	localparam int unsigned SLOT_W    = 3;
	localparam int unsigned TIME_W    = 16;
	localparam int unsigned STATUS_W  = 2;
	localparam int unsigned MASK_W    = 5;

	// Default bank size
	localparam int unsigned NUM_TIMERS_DEF = 5;

	// Time-left value that marks a stopped timer
	localparam logic [TIME_W-1:0] TIME_STOPPED = 16'hFFFF;

	typedef enum logic [CMD_W-1:0] {
		CMD_OPEN  = 3'd0,
		CMD_CLOSE = 3'd1,
		CMD_SET   = 3'd2,
		CMD_START = 3'd3,
		CMD_STOP  = 3'd4,
		CMD_TICK  = 3'd5
	} cmd_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK      = 2'd0,
		ST_INVALID = 2'd1,
		ST_NORES   = 2'd2
	} status_t;

endpackage

/* hdl/one_shot_timer_bank.sv */
// ----------------------------------------------------------------------------
// one_shot_timer_bank: bank of one-shot countdown timers
// Timeouts and time-left values live in two synchronous memories; a tick
// walks all slots through one shared decrementer with read-modify-write.
// ----------------------------------------------------------------------------
// Sequence: open, close, set_timeout, stop and invalid commands load the result
//   at the accepting edge; start reads the timeout, writes it back, then loads
//   the result; tick walks the slots (one slot a cycle), then loads the result.
// Flow: one item at a time; the next beat is taken once the bank is idle and
//   the result register is free or being emptied.
// Reset: clears all open bits and control state; memories are not cleared,
//   each entry is written by open before its value is used.
module one_shot_timer_bank #(
	parameter int unsigned NUM_TIMERS = ostb_pkg::NUM_TIMERS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [ostb_pkg::CMD_W-1:0]     command,
	input  logic [ostb_pkg::SLOT_W-1:0]    slot,
	input  logic [ostb_pkg::TIME_W-1:0]    timeout_ms,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [ostb_pkg::STATUS_W-1:0]  status,
	output logic [ostb_pkg::SLOT_W-1:0]    granted_slot,
	output logic [ostb_pkg::MASK_W-1:0]    expired_mask
);

	localparam int unsigned IDX_W = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
	localparam int unsigned CNT_W = $clog2(NUM_TIMERS + 1);
	localparam int unsigned TW    = ostb_pkg::TIME_W;

	typedef enum logic [1:0] {
		S_IDLE,
		S_START_WR,
		S_TICK,
		S_DONE
	} state_t;

	state_t                       state_q;
	logic [NUM_TIMERS-1:0]        open_q;
	logic [ostb_pkg::SLOT_W-1:0]  slot_q;
	logic [CNT_W-1:0]             cnt_q;
	logic                         valid_s1;
	logic [IDX_W-1:0]             idx_s1;
	logic [ostb_pkg::MASK_W-1:0]  mask_q;

	logic                         out_valid_q;
	ostb_pkg::status_t            status_q;
	logic [ostb_pkg::SLOT_W-1:0]  granted_q;
	logic [ostb_pkg::MASK_W-1:0]  expired_q;

	// Memories and their ports
	logic [TW-1:0]                tmo_mem [NUM_TIMERS];
	logic [TW-1:0]                tl_mem  [NUM_TIMERS];
	logic [TW-1:0]                tmo_rd_q;
	logic [TW-1:0]                tl_rd_q;
	logic                         tmo_we;
	logic [IDX_W-1:0]             tmo_wa;
	logic [TW-1:0]                tmo_wd;
	logic                         tl_we;
	logic [IDX_W-1:0]             tl_wa;
	logic [TW-1:0]                tl_wd;
	logic [IDX_W-1:0]             tl_ra;

	logic                         accept;
	logic                         out_free;
	logic                         res_load;
	logic [IDX_W-1:0]             slot_idx;
	logic [IDX_W-1:0]             slot_q_idx;
	logic                         slot_ok;
	logic                         free_found;
	logic [IDX_W-1:0]             free_idx;
	logic                         tmo_good;
	logic                         wb_live;
	logic                         wb_expire;
	logic [TW-1:0]                wb_dec;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE) && out_free;
	assign accept    = in_valid && in_ready;

	assign out_valid    = out_valid_q;
	assign status       = status_q;
	assign granted_slot = granted_q;
	assign expired_mask = expired_q;

	// Decode the addressed slot: in range and open
	assign slot_idx   = slot[IDX_W-1:0];
	assign slot_q_idx = slot_q[IDX_W-1:0];
	assign slot_ok    = ({1'b0, slot} < (ostb_pkg::SLOT_W + 1)'(NUM_TIMERS))
		? open_q[slot_idx] : 1'b0;
	assign tmo_good   = (timeout_ms != '0) && (timeout_ms != ostb_pkg::TIME_STOPPED);

	// A result loads at this edge: a single-beat command, or the end of start and tick
	assign res_load = (state_q == S_DONE) ? out_free
		: (accept && (command != ostb_pkg::CMD_TICK)
		&& !((command == ostb_pkg::CMD_START) && slot_ok));

	// Find the lowest free slot
	always_comb begin
		free_found = 1'b0;
		free_idx   = '0;
		for (int i = NUM_TIMERS - 1; i >= 0; i--) begin
			if (!open_q[i]) begin
				free_found = 1'b1;
				free_idx   = IDX_W'(i);
			end
		end
	end

	// Shared decrementer for the tick walk
	assign wb_live   = valid_s1 && open_q[idx_s1] && (tl_rd_q != ostb_pkg::TIME_STOPPED);
	assign wb_dec    = tl_rd_q - TW'(1);
	assign wb_expire = wb_live && (tl_rd_q == TW'(1));
	assign tl_ra     = cnt_q[IDX_W-1:0];

	// Steer the memory write ports
	always_comb begin
		tmo_we = 1'b0;
		tmo_wa = slot_idx;
		tmo_wd = timeout_ms;
		tl_we  = 1'b0;
		tl_wa  = slot_idx;
		tl_wd  = ostb_pkg::TIME_STOPPED;
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					case (ostb_pkg::cmd_t'(command))
						ostb_pkg::CMD_OPEN: begin
							tmo_we = free_found;
							tmo_wa = free_idx;
							tl_we  = free_found;
							tl_wa  = free_idx;
						end
						ostb_pkg::CMD_SET: begin
							tmo_we = slot_ok && tmo_good;
						end
						ostb_pkg::CMD_STOP: begin
							tl_we = slot_ok;
						end
						default: begin
						end
					endcase
				end
			end
			S_START_WR: begin
				tl_we = 1'b1;
				tl_wa = slot_q_idx;
				tl_wd = tmo_rd_q;
			end
			S_TICK: begin
				tl_we = wb_live;
				tl_wa = idx_s1;
				tl_wd = wb_expire ? ostb_pkg::TIME_STOPPED : wb_dec;
			end
			default: begin
			end
		endcase
	end

	// Timeout memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (tmo_we) begin
			tmo_mem[tmo_wa] <= tmo_wd;
		end
		tmo_rd_q <= tmo_mem[slot_idx];
	end

	// Time-left memory: one write, one registered read
	always_ff @(posedge clk) begin
		if (tl_we) begin
			tl_mem[tl_wa] <= tl_wd;
		end
		tl_rd_q <= tl_mem[tl_ra];
	end

	// Sequencer, open bits and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			open_q      <= '0;
			slot_q      <= '0;
			cnt_q       <= '0;
			valid_s1    <= 1'b0;
			idx_s1      <= '0;
			mask_q      <= '0;
			out_valid_q <= 1'b0;
			status_q    <= ostb_pkg::ST_OK;
			granted_q   <= '0;
			expired_q   <= '0;
		end else begin
			// Drop the result once taken, unless a new one loads at this edge
			if (out_valid_q && out_ready && !res_load) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						slot_q    <= slot;
						mask_q    <= '0;
						cnt_q     <= '0;
						valid_s1  <= 1'b0;
						granted_q <= '0;
						expired_q <= '0;
						case (ostb_pkg::cmd_t'(command))
							ostb_pkg::CMD_OPEN: begin
								out_valid_q <= 1'b1;
								if (free_found) begin
									open_q[free_idx] <= 1'b1;
									granted_q        <= ostb_pkg::SLOT_W'(free_idx);
									status_q         <= ostb_pkg::ST_OK;
								end else begin
									status_q <= ostb_pkg::ST_NORES;
								end
							end
							ostb_pkg::CMD_CLOSE: begin
								out_valid_q <= 1'b1;
								if (slot_ok) begin
									open_q[slot_idx] <= 1'b0;
									status_q         <= ostb_pkg::ST_OK;
								end else begin
									status_q <= ostb_pkg::ST_INVALID;
								end
							end
							ostb_pkg::CMD_SET: begin
								out_valid_q <= 1'b1;
								status_q    <= (slot_ok && tmo_good)
									? ostb_pkg::ST_OK : ostb_pkg::ST_INVALID;
							end
							ostb_pkg::CMD_STOP: begin
								out_valid_q <= 1'b1;
								status_q    <= slot_ok ? ostb_pkg::ST_OK : ostb_pkg::ST_INVALID;
							end
							ostb_pkg::CMD_START: begin
								if (slot_ok) begin
									state_q <= S_START_WR;
								end else begin
									out_valid_q <= 1'b1;
									status_q    <= ostb_pkg::ST_INVALID;
								end
							end
							ostb_pkg::CMD_TICK: begin
								state_q <= S_TICK;
							end
							default: begin
								out_valid_q <= 1'b1;
								status_q    <= ostb_pkg::ST_INVALID;
							end
						endcase
					end
				end
				S_START_WR: begin
					state_q <= S_DONE;
				end
				S_TICK: begin
					// Advance the walk: issue the next read, retire the previous one
					if (cnt_q != CNT_W'(NUM_TIMERS)) begin
						cnt_q    <= cnt_q + CNT_W'(1);
						valid_s1 <= 1'b1;
						idx_s1   <= cnt_q[IDX_W-1:0];
					end else begin
						valid_s1 <= 1'b0;
						state_q  <= S_DONE;
					end
					if (wb_expire) begin
						mask_q <= mask_q | (ostb_pkg::MASK_W'(1) << idx_s1);
					end
				end
				S_DONE: begin
					// Hold until the result register is free
					if (out_free) begin
						out_valid_q <= 1'b1;
						status_q    <= ostb_pkg::ST_OK;
						granted_q   <= '0;
						expired_q   <= mask_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// Start write-back only ever follows the accepting cycle
	a_start_follows_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_START_WR |-> $past(state_q) == S_IDLE)
		else $error("start write-back not preceded by idle");

	// Walk pipeline stays full once the first read is issued
	a_tick_pipe_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_TICK) && (cnt_q != '0) |-> valid_s1)
		else $error("tick walk lost a slot");

	// Expiry bits only come with an ok result
	a_mask_ok: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (expired_mask != '0) |-> (status == ostb_pkg::ST_OK) && (granted_slot == '0))
		else $error("expiry mask on a non-tick result");

	// A granted slot is open when its result appears
	a_grant_open: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) && (granted_slot != '0) |-> open_q[granted_slot[IDX_W-1:0]])
		else $error("granted slot not open");
`endif

endmodule

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench: self-checking bench for the one-shot timer bank
// Drives command beats from a queue in random bursts and predicts every
// reply from a local model of the slots. Replies are checked field by field
// while the reply side stalls on a changing ready pattern.
// ----------------------------------------------------------------------------
module testbench;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned NUM_TIMERS   = ostb_pkg::NUM_TIMERS_DEF;
	localparam int unsigned RANDOM_BEATS = 1100;
	localparam int unsigned CYCLE_LIMIT  = 400000;
	localparam int unsigned SETTLE_CYCLES = 32;

	// Command codes with no operation behind them
	localparam logic [ostb_pkg::CMD_W-1:0] CMD_SPARE6 = 3'd6;
	localparam logic [ostb_pkg::CMD_W-1:0] CMD_SPARE7 = 3'd7;

	typedef struct {
		logic [ostb_pkg::CMD_W-1:0]  command;
		logic [ostb_pkg::SLOT_W-1:0] slot;
		logic [ostb_pkg::TIME_W-1:0] timeout_ms;
		bit                          drain;
	} timer_cmd_t;

	typedef struct {
		logic [ostb_pkg::STATUS_W-1:0] status;
		logic [ostb_pkg::SLOT_W-1:0]   granted_slot;
		logic [ostb_pkg::MASK_W-1:0]   expired_mask;
	} timer_reply_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          in_valid = 1'b0;
	logic                          in_ready;
	logic [ostb_pkg::CMD_W-1:0]    command = ostb_pkg::CMD_TICK;
	logic [ostb_pkg::SLOT_W-1:0]   slot = '0;
	logic [ostb_pkg::TIME_W-1:0]   timeout_ms = '0;
	logic                          out_valid;
	logic                          out_ready = 1'b0;
	logic [ostb_pkg::STATUS_W-1:0] status;
	logic [ostb_pkg::SLOT_W-1:0]   granted_slot;
	logic [ostb_pkg::MASK_W-1:0]   expired_mask;

	one_shot_timer_bank #(.NUM_TIMERS(NUM_TIMERS)) dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.command      (command),
		.slot         (slot),
		.timeout_ms   (timeout_ms),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.status       (status),
		.granted_slot (granted_slot),
		.expired_mask (expired_mask)
	);

	// Local copy of the slot state
	bit                          bank_open    [NUM_TIMERS];
	logic [ostb_pkg::TIME_W-1:0] bank_timeout [NUM_TIMERS];
	logic [ostb_pkg::TIME_W-1:0] bank_left    [NUM_TIMERS];

	timer_cmd_t   pending_cmds[$];
	timer_reply_t expected_replies[$];
	bit           drain_next;

	int unsigned errors, beats_in, replies_checked, cycles;
	int unsigned n_expired, n_nores, n_invalid;

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Work out the reply to one accepted beat and advance the slot state
	task automatic predict_timer_reply(input logic [ostb_pkg::CMD_W-1:0] cmd,
			input logic [ostb_pkg::SLOT_W-1:0] sl, input logic [ostb_pkg::TIME_W-1:0] tmo);
		timer_reply_t r;
		bit           live;
		r.status = ostb_pkg::ST_OK;
		r.granted_slot = '0;
		r.expired_mask = '0;
		live = (sl < NUM_TIMERS) && bank_open[sl];
		case (cmd)
			ostb_pkg::CMD_OPEN: begin
				r.status = ostb_pkg::ST_NORES;
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (r.status == ostb_pkg::ST_NORES && !bank_open[i]) begin
						bank_open[i] = 1'b1;
						bank_timeout[i] = tmo;
						bank_left[i] = ostb_pkg::TIME_STOPPED;
						r.granted_slot = i[ostb_pkg::SLOT_W-1:0];
						r.status = ostb_pkg::ST_OK;
					end
				end
			end
			ostb_pkg::CMD_CLOSE: begin
				if (live) begin
					bank_open[sl] = 1'b0;
					bank_timeout[sl] = '0;
					bank_left[sl] = ostb_pkg::TIME_STOPPED;
				end else
					r.status = ostb_pkg::ST_INVALID;
			end
			ostb_pkg::CMD_SET: begin
				if (live && tmo != '0 && tmo != ostb_pkg::TIME_STOPPED)
					bank_timeout[sl] = tmo;
				else
					r.status = ostb_pkg::ST_INVALID;
			end
			ostb_pkg::CMD_START: begin
				if (live) bank_left[sl] = bank_timeout[sl];
				else r.status = ostb_pkg::ST_INVALID;
			end
			ostb_pkg::CMD_STOP: begin
				if (live) bank_left[sl] = ostb_pkg::TIME_STOPPED;
				else r.status = ostb_pkg::ST_INVALID;
			end
			ostb_pkg::CMD_TICK: begin
				for (int i = 0; i < NUM_TIMERS; i++) begin
					if (bank_open[i] && bank_left[i] != ostb_pkg::TIME_STOPPED) begin
						bank_left[i] = bank_left[i] - 1'b1;
						if (bank_left[i] == '0) begin
							bank_left[i] = ostb_pkg::TIME_STOPPED;
							if (i < ostb_pkg::MASK_W) r.expired_mask[i] = 1'b1;
						end
					end
				end
			end
			default: r.status = ostb_pkg::ST_INVALID;
		endcase
		if (r.status == ostb_pkg::ST_NORES) n_nores++;
		if (r.status == ostb_pkg::ST_INVALID) n_invalid++;
		n_expired += $countones(r.expired_mask);
		expected_replies.push_back(r);
	endtask

	task automatic queue_cmd(input logic [ostb_pkg::CMD_W-1:0] cmd,
			input logic [ostb_pkg::SLOT_W-1:0] sl, input logic [ostb_pkg::TIME_W-1:0] tmo);
		timer_cmd_t c;
		c.command = cmd;
		c.slot = sl;
		c.timeout_ms = tmo;
		c.drain = drain_next;
		drain_next = 1'b0;
		pending_cmds.push_back(c);
	endtask

	// Pick a timeout: mostly short so that timers run out, now and then any value
	function automatic logic [ostb_pkg::TIME_W-1:0] pick_timeout();
		if ($urandom_range(0, 9) < 7) return ostb_pkg::TIME_W'($urandom_range(1, 6));
		return ostb_pkg::TIME_W'($urandom_range(0, 65535));
	endfunction

	// Driver: present beats in bursts with gaps, hold each until accepted
	int unsigned burst_left, gap_left;

	always @(posedge clk) begin
		timer_cmd_t nxt;
		bit         fire;
		fire = in_valid && in_ready;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (fire) begin
				predict_timer_reply(command, slot, timeout_ms);
				beats_in++;
			end
			if (fire || !in_valid) begin
				if (gap_left != 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_cmds.size() == 0) begin
					in_valid <= 1'b0;
				end else if (pending_cmds[0].drain && expected_replies.size() != 0) begin
					in_valid <= 1'b0;
				end else begin
					nxt = pending_cmds.pop_front();
					command <= nxt.command;
					slot <= nxt.slot;
					timeout_ms <= nxt.timeout_ms;
					in_valid <= 1'b1;
					if (burst_left == 0) begin
						burst_left = $urandom_range(1, 24);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
					end else
						burst_left--;
				end
			end
		end
	end

	// Reply side: ready follows a rotating pattern that is reloaded now and then
	logic [15:0] ready_pat = 16'hFFFF;
	int unsigned pat_left;

	always @(posedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (pat_left == 0) begin
				pat_left = $urandom_range(20, 200);
				case ($urandom_range(0, 3))
					0: ready_pat = 16'hFFFF;
					1: ready_pat = 16'($urandom);
					2: ready_pat = 16'h1111;
					default: ready_pat = 16'($urandom | $urandom);
				endcase
				if (ready_pat == '0) ready_pat = 16'h0001;
			end else
				pat_left--;
			ready_pat = {ready_pat[0], ready_pat[15:1]};
			out_ready <= ready_pat[0];
		end
	end

	// Monitor: compare each accepted reply beat with the oldest prediction
	always @(posedge clk) begin
		timer_reply_t want;
		if (arst_n && out_valid && out_ready) begin
			if (expected_replies.size() == 0) begin
				errors++;
				$display("%0t ns: reply with none expected, got status %0d slot %0d mask %b",
					$time, status, granted_slot, expired_mask);
			end else begin
				want = expected_replies.pop_front();
				replies_checked++;
				if (status !== want.status) begin
					errors++;
					$display("%0t ns: status mismatch, expected %0d, got %0d",
						$time, want.status, status);
				end
				if (granted_slot !== want.granted_slot) begin
					errors++;
					$display("%0t ns: granted_slot mismatch, expected %0d, got %0d",
						$time, want.granted_slot, granted_slot);
				end
				if (expired_mask !== want.expired_mask) begin
					errors++;
					$display("%0t ns: expired_mask mismatch, expected %b, got %b",
						$time, want.expired_mask, expired_mask);
				end
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("%0t ns: run stopped after %0d cycles, %0d replies outstanding",
				$time, cycles, expected_replies.size());
			$display("RESULT: ERROR");
			$finish;
		end
	end

	initial begin
		int unsigned n_random, next_drain, s, t, r;

		for (int i = 0; i < NUM_TIMERS; i++) begin
			bank_open[i] = 1'b0;
			bank_timeout[i] = '0;
			bank_left[i] = ostb_pkg::TIME_STOPPED;
		end

		// Directed: fill the bank, edge timeouts, bad arguments, expiry and wrap
		queue_cmd(ostb_pkg::CMD_OPEN, 3'd0, 16'd0);
		queue_cmd(ostb_pkg::CMD_OPEN, 3'd0, 16'hFFFF);
		queue_cmd(ostb_pkg::CMD_OPEN, 3'd0, 16'd1);
		queue_cmd(ostb_pkg::CMD_OPEN, 3'd0, 16'd2);
		queue_cmd(ostb_pkg::CMD_OPEN, 3'd0, 16'hAAAA);
		queue_cmd(ostb_pkg::CMD_OPEN, 3'd7, 16'h5555);
		queue_cmd(ostb_pkg::CMD_SET, 3'd4, 16'd0);
		queue_cmd(ostb_pkg::CMD_SET, 3'd4, 16'hFFFF);
		queue_cmd(ostb_pkg::CMD_SET, 3'd4, 16'd3);
		queue_cmd(ostb_pkg::CMD_SET, 3'd6, 16'd5);
		for (int i = 0; i < NUM_TIMERS; i++)
			queue_cmd(ostb_pkg::CMD_START, i[ostb_pkg::SLOT_W-1:0], 16'd0);
		repeat (3) queue_cmd(ostb_pkg::CMD_TICK, 3'd0, 16'd0);
		queue_cmd(ostb_pkg::CMD_STOP, 3'd5, 16'd0);
		queue_cmd(CMD_SPARE6, 3'd1, 16'd9);
		queue_cmd(CMD_SPARE7, 3'd2, 16'd9);
		queue_cmd(ostb_pkg::CMD_CLOSE, 3'd1, 16'd0);
		queue_cmd(ostb_pkg::CMD_CLOSE, 3'd1, 16'd0);
		queue_cmd(ostb_pkg::CMD_START, 3'd1, 16'd0);
		queue_cmd(ostb_pkg::CMD_SET, 3'd2, 16'd65534);
		queue_cmd(ostb_pkg::CMD_TICK, 3'd0, 16'd0);

		// Random: mostly set-start-tick runs, with opens, closes and noise mixed in
		drain_next = 1'b1;
		n_random = 0;
		next_drain = 250;
		while (n_random < RANDOM_BEATS) begin
			if (n_random >= next_drain) begin
				drain_next = 1'b1;
				next_drain += 250;
			end
			s = $urandom_range(0, NUM_TIMERS - 1);
			r = $urandom_range(0, 99);
			if (r < 45) begin
				t = $urandom_range(1, 6);
				if ($urandom_range(0, 3) != 0) begin
					queue_cmd(ostb_pkg::CMD_SET, ostb_pkg::SLOT_W'(s), ostb_pkg::TIME_W'(t));
					n_random++;
				end
				queue_cmd(ostb_pkg::CMD_START, ostb_pkg::SLOT_W'(s),
					ostb_pkg::TIME_W'($urandom));
				n_random++;
				repeat ($urandom_range(1, t + 2)) begin
					if ($urandom_range(0, 5) == 0)
						queue_cmd(ostb_pkg::CMD_START,
							ostb_pkg::SLOT_W'($urandom_range(0, NUM_TIMERS - 1)),
							ostb_pkg::TIME_W'($urandom));
					else
						queue_cmd(ostb_pkg::CMD_TICK, ostb_pkg::SLOT_W'($urandom),
							ostb_pkg::TIME_W'($urandom));
					n_random++;
				end
			end else if (r < 56) begin
				queue_cmd(ostb_pkg::CMD_OPEN, ostb_pkg::SLOT_W'($urandom),
					($urandom_range(0, 3) == 0) ? 16'd0 : pick_timeout());
				n_random++;
			end else if (r < 64) begin
				queue_cmd(ostb_pkg::CMD_CLOSE, ($urandom_range(0, 4) == 0)
					? ostb_pkg::SLOT_W'($urandom_range(0, 7)) : ostb_pkg::SLOT_W'(s),
					ostb_pkg::TIME_W'($urandom));
				n_random++;
			end else if (r < 71) begin
				queue_cmd(ostb_pkg::CMD_STOP, ($urandom_range(0, 4) == 0)
					? ostb_pkg::SLOT_W'($urandom_range(0, 7)) : ostb_pkg::SLOT_W'(s),
					ostb_pkg::TIME_W'($urandom));
				n_random++;
			end else if (r < 80) begin
				queue_cmd(ostb_pkg::CMD_W'($urandom_range(0, 7)),
					ostb_pkg::SLOT_W'($urandom_range(0, 7)), ostb_pkg::TIME_W'($urandom));
				n_random++;
			end else if (r < 90) begin
				case ($urandom_range(0, 3))
					0: t = 0;
					1: t = 32'(ostb_pkg::TIME_STOPPED);
					default: t = 32'(pick_timeout());
				endcase
				queue_cmd(ostb_pkg::CMD_SET, ostb_pkg::SLOT_W'($urandom_range(0, 7)),
					ostb_pkg::TIME_W'(t));
				n_random++;
			end else begin
				repeat ($urandom_range(1, 4)) begin
					queue_cmd(ostb_pkg::CMD_TICK, ostb_pkg::SLOT_W'($urandom),
						ostb_pkg::TIME_W'($urandom));
					n_random++;
				end
			end
		end

		repeat (3) @(posedge clk);
		arst_n <= 1'b1;

		// Wait for the bank to drain, then let it settle
		while (pending_cmds.size() != 0 || in_valid || expected_replies.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (expected_replies.size() != 0) begin
			errors++;
			$display("%0t ns: %0d replies never arrived", $time, expected_replies.size());
		end

		$display("Checked %0d replies to %0d command beats in %0d cycles.",
			replies_checked, beats_in, cycles);
		$display("Seen %0d timer expiries, %0d full-bank opens, %0d rejected commands.",
			n_expired, n_nores, n_invalid);
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
